// ===== design/mct_pkg.sv =====
// Shared types, character constants and register indexes for the markup tokenizer.
package mct_pkg;

  // Token kinds as they leave the block.
  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_NUM     = 3'd1,
    KIND_SPACE   = 3'd2,
    KIND_SYM     = 3'd3,
    KIND_NEWLINE = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  // Character classes; escape never leaves the block as a kind.
  typedef enum logic [2:0] {
    CLS_TEXT    = 3'd0,
    CLS_NUM     = 3'd1,
    CLS_SPACE   = 3'd2,
    CLS_SYM     = 3'd3,
    CLS_NEWLINE = 3'd4,
    CLS_ESC     = 3'd6
  } char_class_t;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int         VALUE_BITS = 31;
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam int         CFG_INDEX_BITS = 3;
  localparam logic [2:0] REG_SYMBOL_MAP_0 = 3'd0;
  localparam logic [2:0] REG_SYMBOL_MAP_1 = 3'd1;
  localparam logic [2:0] REG_SYMBOL_MAP_2 = 3'd2;
  localparam logic [2:0] REG_SYMBOL_MAP_3 = 3'd3;

  // Output queue sizing.
  localparam int QUEUE_DEPTH    = 8;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS     = QUEUE_PTR_BITS + 1;
  localparam int MAX_PUSH       = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_char;
    logic        token_first;
    logic        token_last;
    logic [15:0] run_count;
    logic [30:0] number_value;
    logic        run_last;
  } token_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [63:0]               value;
  } cfg_item_t;

  // Up to two tokens produced by one input transaction; b only with a.
  typedef struct packed {
    logic   a_valid;
    logic   b_valid;
    token_t a;
    token_t b;
  } push_t;

endpackage

// ===== design/mct_stream_if.sv =====
// Valid/ready channel interface with a typed payload.
interface mct_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mct_token_core.sv =====
// Tokenizer state, symbol map and per-character next-state logic.
module mct_token_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  mct_pkg::in_item_t  item,
  input  logic               cfg_wr,
  input  mct_pkg::cfg_item_t cfg_item,
  output mct_pkg::push_t     push
);
  import mct_pkg::*;

  typedef struct packed {
    logic [7:0]            ch;
    kind_t                 kind;
    logic                  valid;
    logic                  first;
    logic                  dot;
    logic [COUNT_BITS-1:0] count;
    logic [30:0]           value;
  } held_t;

  logic [3:0][63:0] symbol_map;
  held_t            held, held_next, e;
  logic             esc, esc_next;
  logic             done, cont, dot_step;
  char_class_t      cls;
  logic [7:0]       c;
  push_t            res;

  function automatic logic is_digit(logic [7:0] ch);
    return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  endfunction

  function automatic kind_t cls_kind(char_class_t k);
    kind_t r;
    unique case (k)
      CLS_NUM:     r = KIND_NUM;
      CLS_SPACE:   r = KIND_SPACE;
      CLS_SYM:     r = KIND_SYM;
      CLS_NEWLINE: r = KIND_NEWLINE;
      default:     r = KIND_TEXT;
    endcase
    return r;
  endfunction

  function automatic held_t start_held(logic [7:0] ch, kind_t k);
    held_t h;
    h.ch    = ch;
    h.kind  = k;
    h.valid = 1'b1;
    h.first = 1'b1;
    h.dot   = 1'b0;
    h.count = COUNT_BITS'(1);
    h.value = (k == KIND_NUM) ? 31'(ch[3:0]) : '0;
    return h;
  endfunction

  function automatic token_t emit_held(held_t h, logic last);
    token_t t;
    t.kind         = h.kind;
    t.out_char     = h.ch;
    t.token_first  = h.first;
    t.token_last   = last;
    t.run_count    = 16'(h.count);
    t.number_value = (h.kind == KIND_NUM) ? h.value : '0;
    t.run_last     = 1'b0;
    return t;
  endfunction

  function automatic token_t end_token();
    token_t t;
    t              = '0;
    t.kind         = KIND_END;
    t.token_first  = 1'b1;
    t.token_last   = 1'b1;
    t.run_last     = 1'b1;
    return t;
  endfunction

  // value*10 + digit, clamped to the 31-bit maximum
  function automatic logic [30:0] value_step(logic [30:0] v, logic [7:0] ch);
    logic [34:0] p;
    p = ({4'b0, v} << 3) + ({4'b0, v} << 1) + 35'(ch[3:0]);
    return (|p[34:31]) ? VALUE_MAX : p[30:0];
  endfunction

  assign c = item.in_byte;

  // Priority: symbol map, digit, space, newline, backslash, text.
  always_comb begin
    if (symbol_map[c[7:6]][c[5:0]])  cls = CLS_SYM;
    else if (is_digit(c))            cls = CLS_NUM;
    else if (c == CHAR_SPACE)        cls = CLS_SPACE;
    else if (c == CHAR_NL)           cls = CLS_NEWLINE;
    else if (c == CHAR_BSLASH)       cls = CLS_ESC;
    else                             cls = CLS_TEXT;
  end

  always_comb begin
    held_next = held;
    esc_next  = esc;
    res       = '0;
    e         = held;
    done      = 1'b0;
    cont      = 1'b0;
    dot_step  = 1'b0;
    if (item_valid) begin
      if (item.is_end) begin
        // flush a pending backslash or the held character, then the end token
        if (esc) begin
          res.a       = emit_held(start_held(CHAR_BSLASH, KIND_TEXT), 1'b1);
          res.a_valid = 1'b1;
        end else if (held.valid) begin
          res.a       = emit_held(held, 1'b1);
          res.a_valid = 1'b1;
        end
        if (res.a_valid) begin
          res.b       = end_token();
          res.b_valid = 1'b1;
        end else begin
          res.a       = end_token();
          res.a_valid = 1'b1;
        end
        held_next = '0;
        esc_next  = 1'b0;
      end else begin
        if (esc) begin
          esc_next = 1'b0;
          if (cls == CLS_SYM || c == CHAR_DOT || c == CHAR_BSLASH) begin
            held_next = start_held(c, KIND_TEXT);
            done      = 1'b1;
          end else if (c == CHAR_N) begin
            held_next = start_held(CHAR_NL, KIND_TEXT);
            done      = 1'b1;
          end else begin
            // backslash stands for itself and this char is handled as usual
            e = start_held(CHAR_BSLASH, KIND_TEXT);
          end
        end
        if (!done) begin
          if (e.valid) begin
            case (e.kind) inside
              KIND_TEXT: cont = (cls == CLS_TEXT);
              KIND_NUM: begin
                if (!e.dot) begin
                  if (is_digit(c)) begin
                    cont = 1'b1;
                  end else if (c == CHAR_DOT) begin
                    cont     = 1'b1;
                    dot_step = 1'b1;
                  end
                end
              end
              KIND_SPACE, KIND_SYM: cont = (c == e.ch);
              default: cont = 1'b0;
            endcase
            res.a          = emit_held(e, !cont);
            res.a.run_last = 1'b1;
            res.a_valid    = 1'b1;
            if (cont) begin
              held_next       = e;
              held_next.ch    = c;
              held_next.first = 1'b0;
              if (!(&e.count)) held_next.count = e.count + COUNT_BITS'(1);
              if (e.kind == KIND_NUM) begin
                if (dot_step) held_next.dot   = 1'b1;
                else          held_next.value = value_step(e.value, c);
              end
            end
          end
          if (!(e.valid && cont)) begin
            if (cls == CLS_ESC) begin
              held_next.valid = 1'b0;
              esc_next        = 1'b1;
            end else begin
              held_next = start_held(c, cls_kind(cls));
            end
          end
        end
      end
    end
  end

  assign push = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      esc  <= 1'b0;
    end else begin
      held <= held_next;
      esc  <= esc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_map <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_item.index)
        REG_SYMBOL_MAP_0: symbol_map[0] <= cfg_item.value;
        REG_SYMBOL_MAP_1: symbol_map[1] <= cfg_item.value;
        REG_SYMBOL_MAP_2: symbol_map[2] <= cfg_item.value;
        REG_SYMBOL_MAP_3: symbol_map[3] <= cfg_item.value;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/mct_out_queue.sv =====
// Eight-entry token queue taking up to two tokens per cycle, giving one.
module mct_out_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  mct_pkg::push_t                push,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mct_pkg::token_t               out_data,
  output logic [mct_pkg::LEVEL_BITS-1:0] level
);
  import mct_pkg::*;

  token_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] rd_ptr, wr_ptr;
  logic [LEVEL_BITS-1:0]     push_n;
  logic                      pop;

  assign out_valid = (level != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign push_n    = LEVEL_BITS'(push.a_valid) + LEVEL_BITS'(push.b_valid);

  always_ff @(posedge clk) begin
    if (push.a_valid) entries[wr_ptr] <= push.a;
    if (push.b_valid) entries[wr_ptr + QUEUE_PTR_BITS'(1)] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[QUEUE_PTR_BITS-1:0];
      if (pop) rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      level  <= level + push_n - LEVEL_BITS'(pop);
    end
  end

endmodule

// ===== design/markup_char_tokenizer.sv =====
// Top level of the markup character tokenizer: input register, core, token queue.
//
//   channel  dir  payload                                   transaction
//   chars    in   in_byte, is_end                           one character or end mark
//   tokens   out  kind, out_char, first/last, counts, last  one token character
//   cfg      in   index, value (64 bit)                     one symbol map word
//
// One character transaction is taken every cycle while chars.ready is high. It is
// held in the input register, where the core classifies it and updates the token
// state; its tokens enter the 8-entry queue at the next edge. An end mark gives
// up to two tokens, drained one per cycle from the queue while tokens.ready is high.
// chars.ready drops only while the queue is within reach of filling; tokens
// stalls never reach the core directly. cfg is always ready.
// rst is synchronous: token state, symbol map and queue are cleared.
module markup_char_tokenizer #(
  parameter int COUNT_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  mct_stream_if.sink   chars,
  mct_stream_if.source tokens,
  mct_stream_if.sink   cfg
);
  import mct_pkg::*;

  // input register
  logic     stage_valid;
  in_item_t stage_item;

  push_t                 push;
  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS:0]   reserved;
  logic                  accept;

  // Room is reserved for the item in the input register and the one arriving.
  assign reserved    = {1'b0, level} + (stage_valid ? (LEVEL_BITS+1)'(MAX_PUSH) : '0);
  assign chars.ready = reserved <= (LEVEL_BITS+1)'(QUEUE_DEPTH - MAX_PUSH);
  assign accept      = chars.valid && chars.ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage_item <= chars.data;
  end

  mct_token_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (stage_valid),
    .item       (stage_item),
    .cfg_wr     (cfg.valid && cfg.ready),
    .cfg_item   (cfg.data),
    .push       (push)
  );

  mct_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .out_data  (tokens.data),
    .level     (level)
  );

`ifndef SYNTHESIS
  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_BITS'(QUEUE_DEPTH))
    else $error("token queue overflow");

  // an end mark in the input register always leaves its end token queued
  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_item.is_end |=> level != '0)
    else $error("end token not queued");

  // a second token only ever comes with a first one
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.b_valid |-> push.a_valid && stage_valid)
    else $error("second token without first");
`endif

endmodule

// ===== tb/sv/tb_markup_char_tokenizer.sv =====
// Testbench for markup_char_tokenizer: directed and random streams checked by a scoreboard.
`timescale 1ns / 1ps

module tb_markup_char_tokenizer;
  import mct_pkg::*;

  localparam int          TOKEN_COUNT_BITS = 16;
  localparam logic [15:0] COUNT_LIMIT      = 16'((32'd1 << TOKEN_COUNT_BITS) - 1);
  // Indexes past the symbol map; writes to them must leave the map alone.
  localparam logic [2:0]  REG_UNUSED_LO    = 3'd4;
  localparam logic [2:0]  REG_UNUSED_HI    = 3'd7;
  localparam int          IDLE_PERCENT     = 26;
  localparam int          STALL_CYCLES     = 300;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          LONG_RUN_CHARS   = 40;
  localparam int          SIM_LIMIT_NS     = 5_000_000;

  // Scoreboard: mirrors the tokenizer state and holds the tokens still owed.
  class token_scoreboard;
    logic [63:0] sym_map [4];
    logic [7:0]  held_char;
    kind_t       held_kind;
    bit          held_valid;
    bit          held_first;
    bit          esc_pend;
    bit          dot_taken;
    logic [15:0] char_count;
    logic [30:0] digit_value;
    token_t      owed_q[$];
    int          errors;

    function new();
      foreach (sym_map[i]) sym_map[i] = '0;
      errors = 0;
      clear_tokens();
    endfunction

    function void clear_tokens();
      held_char   = '0;
      held_kind   = KIND_TEXT;
      held_valid  = 0;
      held_first  = 0;
      esc_pend    = 0;
      dot_taken   = 0;
      char_count  = '0;
      digit_value = '0;
    endfunction

    function void set_map(logic [2:0] idx, logic [63:0] val);
      if (idx <= REG_SYMBOL_MAP_3) sym_map[idx[1:0]] = val;
    endfunction

    function bit is_sym(logic [7:0] c);
      return sym_map[c[7:6]][c[5:0]];
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // Symbol map wins over every other class, so a mapped backslash is no escape.
    function char_class_t classify(logic [7:0] c);
      if (is_sym(c)) return CLS_SYM;
      if (is_digit(c)) return CLS_NUM;
      if (c == CHAR_SPACE) return CLS_SPACE;
      if (c == CHAR_NL) return CLS_NEWLINE;
      if (c == CHAR_BSLASH) return CLS_ESC;
      return CLS_TEXT;
    endfunction

    function void push_token(kind_t k, logic [7:0] ch, bit f, bit l, logic [15:0] cnt,
                             logic [30:0] val);
      token_t t;
      t.kind         = k;
      t.out_char     = ch;
      t.token_first  = f;
      t.token_last   = l;
      t.run_count    = cnt;
      t.number_value = val;
      t.run_last     = 1'b0;
      owed_q.insert(owed_q.size(), t);
    endfunction

    function void emit_held(bit last);
      push_token(held_kind, held_char, held_first, last, char_count,
                 held_kind == KIND_NUM ? digit_value : '0);
    endfunction

    function void start_token(logic [7:0] c, kind_t k);
      held_char   = c;
      held_kind   = k;
      held_valid  = 1;
      held_first  = 1;
      dot_taken   = 0;
      char_count  = 16'd1;
      digit_value = (k == KIND_NUM && is_digit(c)) ? 31'(c - CHAR_ZERO) : '0;
    endfunction

    // Flag the newest token of this transaction as its last one.
    function void mark_run_end(int n0);
      if (owed_q.size() > n0) owed_q[$].run_last = 1'b1;
    endfunction

    function void note_char(in_item_t it);
      logic [7:0]  c;
      char_class_t cls;
      bit          cont;
      bit          dot;
      int          n0;
      logic [35:0] v;
      c    = it.in_byte;
      n0   = owed_q.size();
      cont = 0;
      dot  = 0;
      if (it.is_end) begin
        // flush: a lone pending backslash leaves as one-char text
        if (esc_pend) push_token(KIND_TEXT, CHAR_BSLASH, 1, 1, 16'd1, '0);
        else if (held_valid) emit_held(1);
        push_token(KIND_END, 8'h00, 1, 1, 16'd0, '0);
        clear_tokens();
        mark_run_end(n0);
        return;
      end
      cls = classify(c);
      if (esc_pend) begin
        esc_pend = 0;
        if (cls == CLS_SYM || c == CHAR_DOT || c == CHAR_BSLASH) begin
          start_token(c, KIND_TEXT);
          return;
        end
        if (c == CHAR_N) begin
          start_token(CHAR_NL, KIND_TEXT);
          return;
        end
        // plain escape: backslash is text, current byte handled below
        start_token(CHAR_BSLASH, KIND_TEXT);
      end
      if (held_valid) begin
        case (held_kind)
          KIND_TEXT: cont = (cls == CLS_TEXT);
          KIND_NUM: begin
            // digits continue even when mapped as symbols; one dot closes the run
            if (!dot_taken) begin
              if (is_digit(c)) cont = 1;
              else if (c == CHAR_DOT) begin
                cont = 1;
                dot  = 1;
              end
            end
          end
          KIND_SPACE, KIND_SYM: cont = (c == held_char);
          default: cont = 0;
        endcase
        emit_held(!cont);
        if (cont) begin
          held_char  = c;
          held_first = 0;
          if (char_count < COUNT_LIMIT) char_count++;
          if (held_kind == KIND_NUM) begin
            if (dot) dot_taken = 1;
            else begin
              v = {5'b0, digit_value} * 36'd10 + {28'b0, c - CHAR_ZERO};
              digit_value = (v > {5'b0, VALUE_MAX}) ? VALUE_MAX : v[30:0];
            end
          end
          mark_run_end(n0);
          return;
        end
        held_valid = 0;
      end
      if (cls == CLS_ESC) begin
        held_valid = 0;
        esc_pend   = 1;
      end else begin
        start_token(c, kind_t'(cls));
      end
      mark_run_end(n0);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: token %s mismatch: expected %0h, actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_token(token_t got);
      token_t exp;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none, actual %0h", $time, got);
        return;
      end
      exp = owed_q.pop_front();
      cmp("kind", 32'(exp.kind), 32'(got.kind));
      cmp("out_char", 32'(exp.out_char), 32'(got.out_char));
      cmp("token_first", 32'(exp.token_first), 32'(got.token_first));
      cmp("token_last", 32'(exp.token_last), 32'(got.token_last));
      cmp("run_count", 32'(exp.run_count), 32'(got.run_count));
      cmp("number_value", 32'(exp.number_value), 32'(got.number_value));
      cmp("run_last", 32'(exp.run_last), 32'(got.run_last));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  mct_stream_if #(.payload_t(in_item_t))  chars_ch ();
  mct_stream_if #(.payload_t(token_t))    tokens_ch ();
  mct_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

  markup_char_tokenizer #(.COUNT_BITS(TOKEN_COUNT_BITS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_ch),
    .tokens (tokens_ch),
    .cfg    (cfg_ch)
  );

  token_scoreboard sb = new();

  // Traffic shaping: idle_on enables random gaps on both sides; toggling
  // hold_req asks the token side for one long back-pressure stretch.
  bit idle_on;
  bit hold_req;
  bit hold_ack;
  int hold_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Token side: check every accepted transaction, then pick next cycle's ready.
  // The hold counter lives here so the stall length is counted in clocks.
  always @(posedge clk) begin
    if (!rst && tokens_ch.valid && tokens_ch.ready) sb.check_token(tokens_ch.data);
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = STALL_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      tokens_ch.ready <= 1'b0;
    end else if (idle_on) begin
      tokens_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end else begin
      tokens_ch.ready <= 1'b1;
    end
  end

  // Offer one char transaction and note it once accepted. valid stays high
  // across back-to-back transactions; a gap lowers it in an earlier step.
  // Each gap cycle repeats with the idle odds, so gaps take the idle share.
  task automatic send_char(input logic [7:0] b, input bit e);
    in_item_t it;
    it.in_byte = b;
    it.is_end  = e;
    if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      chars_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
    end
    chars_ch.valid <= 1'b1;
    chars_ch.data  <= it;
    do @(posedge clk); while (!chars_ch.ready);
    sb.note_char(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  // Stop offering, wait for every owed token, then let the core settle:
  // a char that makes no token may still sit in the input register.
  task automatic wait_quiet();
    chars_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Config writes happen only with the block quiet (callers drain first).
  // cfg valid drops after each write before the next one starts.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_item_t w;
    w.index = idx;
    w.value = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_map(idx, val);
    @(posedge clk);
  endtask

  // Rebuild all four map words from a list of symbol characters.
  task automatic load_symbols(input string s);
    logic [63:0] w [4];
    logic [7:0]  b;
    foreach (w[r]) w[r] = '0;
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      w[b[7:6]][b[5:0]] = 1'b1;
    end
    for (int r = 0; r < 4; r++) write_reg(3'(r), w[r]);
  endtask

  // Try for a byte that the current map treats as a symbol.
  function automatic logic [7:0] pick_symbol();
    logic [7:0] b;
    for (int i = 0; i < 16; i++) begin
      b = 8'($urandom_range(255));
      if (sb.is_sym(b)) return b;
    end
    return 8'h2A;
  endfunction

  // Random stream built mostly from well-formed token shapes with random
  // content; the rest is raw noise bytes and end marks.
  task automatic random_stream(input int n);
    int         sent;
    int         r;
    int         runs;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 14) begin
        runs = $urandom_range(1, 6);
        repeat (runs) send_char(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        sent += runs;
      end else if (r < 32) begin
        // long runs push the value past 2^31-1
        runs = $urandom_range(1, 12);
        repeat (runs) send_char(8'($urandom_range(CHAR_ZERO, CHAR_NINE)), 1'b0);
        sent += runs;
        if ($urandom_range(99) < 30) begin
          send_char(CHAR_DOT, 1'b0);
          sent++;
        end
      end else if (r < 42) begin
        runs = $urandom_range(1, 5);
        repeat (runs) send_char(CHAR_SPACE, 1'b0);
        sent += runs;
      end else if (r < 54) begin
        runs = $urandom_range(1, 4);
        b = pick_symbol();
        repeat (runs) send_char(b, 1'b0);
        sent += runs;
      end else if (r < 60) begin
        send_char(CHAR_NL, 1'b0);
        sent++;
      end else if (r < 74) begin
        send_char(CHAR_BSLASH, 1'b0);
        case ($urandom_range(4))
          0: b = pick_symbol();
          1: b = CHAR_DOT;
          2: b = CHAR_BSLASH;
          3: b = CHAR_N;
          default: b = 8'($urandom_range(255));
        endcase
        send_char(b, 1'b0);
        sent += 2;
      end else if (r < 81) begin
        // in_byte is don't-care on an end mark; randomize it anyway
        send_char(8'($urandom_range(255)), 1'b1);
        sent++;
      end else begin
        send_char(8'($urandom_range(255)), 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    hold_ack        = 1'b0;
    hold_left       = 0;
    chars_ch.valid  = 1'b0;
    chars_ch.data   = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    tokens_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty map straight out of reset.
    random_stream(150);

    // Directed: '5' is mapped so a digit run continues through a symbol digit.
    wait_quiet();
    load_symbols("*#5");
    send_text("ab  15..**#\n");
    // escapes: symbol, newline letter, dot, backslash, then plain escape before a digit
    send_text("\\*\\n\\.\\\\\\7");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_BSLASH, 1'b0);
    send_char(8'h00, 1'b1);   // flushes the lone backslash
    send_char(8'hFF, 1'b1);   // end with nothing held

    // Markup punctuation; one long token-side stall mid-phase fills the queue.
    wait_quiet();
    load_symbols("*#_~`[]()!<>=+-|");
    random_stream(100);
    hold_req <= ~hold_req;
    random_stream(300);

    // Every byte a symbol: no escapes, numbers never start.
    wait_quiet();
    for (int r = 0; r < 4; r++) write_reg(3'(r), {64{1'b1}});
    random_stream(150);

    // Backslash and some digits mapped; the sender pauses until drained.
    wait_quiet();
    load_symbols("\\*#0179");
    random_stream(150);
    wait_quiet();
    random_stream(150);

    // Random words; writes past the map must be ignored.
    wait_quiet();
    for (int r = 0; r < 4; r++) write_reg(3'(r), {$urandom(), $urandom()});
    write_reg(REG_UNUSED_LO, {$urandom(), $urandom()});
    write_reg(REG_UNUSED_HI, {64{1'b1}});
    random_stream(300);

    // Map cleared explicitly; then one long text run with both sides gapless.
    wait_quiet();
    for (int r = 0; r < 4; r++) write_reg(3'(r), '0);
    random_stream(150);
    idle_on = 1'b0;
    repeat (LONG_RUN_CHARS) send_char(8'h61, 1'b0);
    send_char(8'h00, 1'b1);

    // Back to punctuation with no gaps on either side.
    wait_quiet();
    load_symbols("*#_~`[]()!<>=+-|");
    random_stream(200);

    wait_quiet();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: tokens never seen: expected 0, actual %0d", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("tb_markup_char_tokenizer OK");
    end else begin
      $display("tb_markup_char_tokenizer NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(SIM_LIMIT_NS);
    $display("tb_markup_char_tokenizer NOT OK");
    $finish;
  end

endmodule
